### src/mulaw_pcm_sample_converter_unit_macros.svh
`ifndef MULAW_PCM_SAMPLE_CONVERTER_UNIT_MACROS_SVH
`define MULAW_PCM_SAMPLE_CONVERTER_UNIT_MACROS_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define MPSC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk, off while rst_n is low
`define MPSC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mpsc_pkg.sv
package mpsc_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int GAIN_BITS      = 16;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int VAL_BITS       = 20;
    localparam int MUL_BITS       = GAIN_BITS + 1;
    localparam int PROD_BITS      = 2 * MUL_BITS;
    localparam int PADDR_BITS     = 4;
    localparam int PDATA_BITS     = 32;

    localparam logic [7:0]  MU_BIAS = 8'h84;
    localparam logic [15:0] MU_CLIP = 16'd32635;

    localparam logic [1:0] FMT_MULAW = 2'd0;
    localparam logic [1:0] FMT_S16   = 2'd1;
    localparam logic [1:0] FMT_U8    = 2'd2;

    localparam logic [1:0] MODE_PASS    = 2'd0;
    localparam logic [1:0] MODE_DOWNMIX = 2'd1;
    localparam logic [1:0] MODE_DUP     = 2'd2;

    localparam logic [1:0] REG_INPUT_FORMAT  = 2'd0;
    localparam logic [1:0] REG_OUTPUT_FORMAT = 2'd1;
    localparam logic [1:0] REG_CHANNEL_MODE  = 2'd2;

    localparam logic signed [PROD_BITS-1:0] PCM_MIN_P = -(PROD_BITS'(32768));
    localparam logic signed [PROD_BITS-1:0] ROUND_P   = PROD_BITS'(1 << (GAIN_FRAC_BITS - 1));
    localparam logic signed [PROD_BITS-1:0] VAL_MAX_P = PROD_BITS'((1 << (VAL_BITS - 1)) - 1);
    localparam logic signed [PROD_BITS-1:0] VAL_MIN_P = -(PROD_BITS'(1 << (VAL_BITS - 1)));
    localparam logic signed [PROD_BITS-1:0] U8_OFS_P  = PROD_BITS'(128 * 32768 + 16384);

    localparam logic signed [VAL_BITS-1:0] PCM_MAX_V  = VAL_BITS'(32767);
    localparam logic signed [VAL_BITS-1:0] PCM_TOP_V  = VAL_BITS'(32768);
    localparam logic signed [VAL_BITS-1:0] PCM_MIN_V  = -(VAL_BITS'(32768));

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_VAL,
        S_GAIN,
        S_SCALE,
        S_MIX,
        S_ENC,
        S_PACK,
        S_EMIT
    } state_t;

    function automatic logic signed [MUL_BITS-1:0] mulaw_decode(input logic [7:0] b);
        logic [7:0]  u;
        logic [15:0] base;
        logic [15:0] mag;
        u    = ~b;
        base = 16'({u[3:0], 3'b000}) + 16'(MU_BIAS);
        mag  = (base << u[6:4]) - 16'(MU_BIAS);
        if (u[7])
        begin
            return -$signed({1'b0, mag});
        end
        return $signed({1'b0, mag});
    endfunction

    function automatic logic [7:0] mulaw_encode(input logic signed [15:0] s);
        logic signed [17:0] ext;
        logic [15:0]        pcm;
        logic [2:0]         seg;
        logic [3:0]         mant;
        logic [7:0]         mask;
        ext = 18'(s);
        if (s[15])
        begin
            pcm  = 16'(18'(MU_BIAS) - ext);
            mask = 8'h7F;
        end
        else
        begin
            pcm  = 16'(18'(MU_BIAS) + ext);
            mask = 8'hFF;
        end
        if (pcm > 16'(MU_BIAS) + MU_CLIP)
        begin
            pcm = 16'(MU_BIAS) + MU_CLIP;
        end
        seg = 3'd0;
        for (int k = 0; k < 7; k++)
        begin
            if (pcm >= (16'h0100 << k))
            begin
                seg = seg + 3'd1;
            end
        end
        mant = 4'(pcm >> (4'(seg) + 4'd3));
        return {1'b0, seg, mant} ^ mask;
    endfunction

endpackage

### src/mulaw_pcm_sample_converter_unit.sv
// Audio sample converter: decode, peak track, gain, channel mix, encode.
// Input channel (in_valid/in_stall) carries sample_in, gain, last_in; one beat
// is taken when in_valid is high and in_stall is low. Output channel
// (out_valid/out_stall) carries sample_out, last_out, peak_level, malformed.
// The APB port sets input_format (0x0), output_format (0x4), channel_mode
// (0x8); write it only while the block is idle.
// One item runs through an eight-step sequencer around a single shared
// 17x17 multiplier (offset decode, gain, offset encode). The result is
// loaded into the output register from the emit step, twice in duplicate
// mode; a new beat is taken only once the sequencer is back in idle. A
// held left sample in downmix mode ends at the mix step and gives no result.
// When the receiver stalls, the output register holds its beat; the
// sequencer waits in its emit step until the register frees, and in_stall
// stays high meanwhile. A finished result may wait in the output register
// while the next input beat is taken.
// Reset clears the peak, the pair phase and the output valid, and sets the
// registers to signed 16-bit in and out with pass through.
`include "mulaw_pcm_sample_converter_unit_macros.svh"

module mulaw_pcm_sample_converter_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mpsc_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [mpsc_pkg::PDATA_BITS-1:0]   pwdata,
    output logic [mpsc_pkg::PDATA_BITS-1:0]   prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [mpsc_pkg::SAMPLE_BITS-1:0]  sample_in,
    input  logic [mpsc_pkg::GAIN_BITS-1:0]    gain,
    input  logic                              last_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [mpsc_pkg::SAMPLE_BITS-1:0]  sample_out,
    output logic                              last_out,
    output logic [mpsc_pkg::SAMPLE_BITS-1:0]  peak_level,
    output logic                              malformed
);
    import mpsc_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [1:0] in_fmt_reg;
    logic [1:0] out_fmt_reg;
    logic [1:0] mode_reg;

    logic [SAMPLE_BITS-1:0]       sample_reg;
    logic [GAIN_BITS-1:0]         gain_reg;
    logic                         last_reg;
    logic signed [PROD_BITS-1:0]  prod_reg;
    logic signed [MUL_BITS-1:0]   v_reg;
    logic signed [VAL_BITS-1:0]   g_reg;
    logic signed [VAL_BITS-1:0]   held_reg;
    logic signed [VAL_BITS-1:0]   val_reg;
    logic signed [15:0]           s16_reg;
    logic [SAMPLE_BITS-1:0]       code_reg;
    logic                         phase_reg;
    logic [SAMPLE_BITS-1:0]       peak_reg;
    logic                         bad_reg;
    logic                         fin_reg;
    logic                         dup_reg;

    logic                         out_valid_reg;
    logic [SAMPLE_BITS-1:0]       sample_out_reg;
    logic                         last_out_reg;
    logic [SAMPLE_BITS-1:0]       peak_out_reg;
    logic                         malformed_reg;

    logic signed [MUL_BITS-1:0]   mul_a;
    logic signed [MUL_BITS-1:0]   mul_b;
    logic signed [PROD_BITS-1:0]  mul_p;

    logic signed [MUL_BITS-1:0]   off_v;
    logic signed [MUL_BITS-1:0]   dec_v;
    logic signed [MUL_BITS-1:0]   dec_abs;
    logic signed [PROD_BITS-1:0]  rnd_p;
    logic signed [PROD_BITS-1:0]  shr_p;
    logic signed [VAL_BITS-1:0]   g_sat;
    logic signed [VAL_BITS-1:0]   left_v;
    logic signed [VAL_BITS:0]     mix_sum;
    logic signed [VAL_BITS-1:0]   mix_half;
    logic signed [MUL_BITS-1:0]   enc_c;
    logic signed [15:0]           enc_s16;
    logic signed [PROD_BITS-1:0]  u8_sum;
    logic [SAMPLE_BITS-1:0]       code_next;

    logic downmix;
    logic hold_only;
    logic out_free;
    logic out_load;
    logic cfg_wr;
    logic [1:0] cfg_idx;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = paddr[PADDR_BITS-1:2];
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == S_EMIT) && out_free;
    assign downmix  = (mode_reg == MODE_DOWNMIX);
    assign hold_only = downmix && !phase_reg && !last_reg;

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign last_out   = last_out_reg;
    assign peak_level = peak_out_reg;
    assign malformed  = malformed_reg;

    always_comb
    begin
        case (cfg_idx)
            REG_INPUT_FORMAT:  prdata = PDATA_BITS'(in_fmt_reg);
            REG_OUTPUT_FORMAT: prdata = PDATA_BITS'(out_fmt_reg);
            REG_CHANNEL_MODE:  prdata = PDATA_BITS'(mode_reg);
            default:           prdata = '0;
        endcase
    end

    assign mul_p = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                mul_a      = MUL_BITS'($signed({1'b0, sample_reg[7:0]})) - MUL_BITS'(128);
                mul_b      = MUL_BITS'(258);
                state_next = S_VAL;
            end
            S_VAL:
            begin
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                mul_a      = v_reg;
                mul_b      = $signed({1'b0, gain_reg});
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                state_next = S_MIX;
            end
            S_MIX:
            begin
                state_next = hold_only ? S_IDLE : S_ENC;
            end
            S_ENC:
            begin
                mul_a      = enc_c;
                mul_b      = MUL_BITS'(127);
                state_next = S_PACK;
            end
            S_PACK:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free && !dup_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        off_v = (prod_reg < PCM_MIN_P) ? MUL_BITS'(PCM_MIN_P) : prod_reg[MUL_BITS-1:0];
        case (in_fmt_reg)
            FMT_MULAW: dec_v = mulaw_decode(sample_reg[7:0]);
            FMT_U8:    dec_v = off_v;
            default:   dec_v = MUL_BITS'($signed(sample_reg));
        endcase
        dec_abs = dec_v[MUL_BITS-1] ? -dec_v : dec_v;

        rnd_p = prod_reg + ROUND_P;
        shr_p = rnd_p >>> GAIN_FRAC_BITS;
        if (shr_p > VAL_MAX_P)
        begin
            g_sat = VAL_MAX_P[VAL_BITS-1:0];
        end
        else if (shr_p < VAL_MIN_P)
        begin
            g_sat = VAL_MIN_P[VAL_BITS-1:0];
        end
        else
        begin
            g_sat = shr_p[VAL_BITS-1:0];
        end

        left_v   = phase_reg ? held_reg : '0;
        mix_sum  = (VAL_BITS+1)'(left_v) + (VAL_BITS+1)'(g_reg);
        mix_half = VAL_BITS'(mix_sum >>> 1);

        if (val_reg > PCM_TOP_V)
        begin
            enc_c = MUL_BITS'(PCM_TOP_V);
        end
        else if (val_reg < PCM_MIN_V)
        begin
            enc_c = MUL_BITS'(PCM_MIN_V);
        end
        else
        begin
            enc_c = val_reg[MUL_BITS-1:0];
        end
        enc_s16 = (val_reg > PCM_MAX_V) ? 16'sh7FFF : enc_c[15:0];

        u8_sum = prod_reg + U8_OFS_P;
        case (out_fmt_reg)
            FMT_MULAW: code_next = SAMPLE_BITS'(mulaw_encode(s16_reg));
            FMT_U8:    code_next = SAMPLE_BITS'(u8_sum[22:15]);
            default:   code_next = s16_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_fmt_reg    <= FMT_S16;
            out_fmt_reg   <= FMT_S16;
            mode_reg      <= MODE_PASS;
            phase_reg     <= 1'b0;
            peak_reg      <= '0;
            held_reg      <= '0;
            dup_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_idx)
                    REG_INPUT_FORMAT:  in_fmt_reg  <= pwdata[1:0];
                    REG_OUTPUT_FORMAT: out_fmt_reg <= pwdata[1:0];
                    REG_CHANNEL_MODE:  mode_reg    <= pwdata[1:0];
                    default:           ;
                endcase
            end

            if (state_reg == S_VAL && dec_abs[SAMPLE_BITS-1:0] > peak_reg)
            begin
                peak_reg <= dec_abs[SAMPLE_BITS-1:0];
            end

            if (state_reg == S_MIX)
            begin
                if (hold_only)
                begin
                    held_reg  <= g_reg;
                    phase_reg <= 1'b1;
                end
                else
                begin
                    phase_reg <= 1'b0;
                    dup_reg   <= (mode_reg == MODE_DUP);
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                if (dup_reg)
                begin
                    dup_reg <= 1'b0;
                end
                else if (fin_reg)
                begin
                    peak_reg <= '0;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            sample_reg <= sample_in;
            gain_reg   <= gain;
            last_reg   <= last_in;
        end
        if (state_reg == S_DEC || state_reg == S_GAIN || state_reg == S_ENC)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == S_VAL)
        begin
            v_reg <= dec_v;
        end
        if (state_reg == S_SCALE)
        begin
            g_reg <= g_sat;
        end
        if (state_reg == S_MIX)
        begin
            fin_reg <= last_reg;
            if (downmix)
            begin
                val_reg <= mix_half;
                bad_reg <= !phase_reg;
            end
            else
            begin
                val_reg <= g_reg;
                bad_reg <= 1'b0;
            end
        end
        if (state_reg == S_ENC)
        begin
            s16_reg <= enc_s16;
        end
        if (state_reg == S_PACK)
        begin
            code_reg <= code_next;
        end
        if (out_load)
        begin
            sample_out_reg <= code_reg;
            if (dup_reg)
            begin
                last_out_reg  <= 1'b0;
                peak_out_reg  <= '0;
                malformed_reg <= 1'b0;
            end
            else
            begin
                last_out_reg  <= fin_reg;
                peak_out_reg  <= fin_reg ? peak_reg : '0;
                malformed_reg <= bad_reg;
            end
        end
    end

    `MPSC_ASSERT_NXT(a_accept_starts_decode, in_valid && !in_stall, state_reg == S_DEC, "accepted beat did not start decode")
    `MPSC_ASSERT_IMP(a_peak_only_on_last, out_valid && !last_out, peak_level == '0 && !malformed, "peak or malformed on a non-last beat")
    `MPSC_ASSERT_IMP(a_peak_in_range, 1'b1, peak_reg <= 16'h8000, "peak accumulator above full scale")
    `MPSC_ASSERT_NXT(a_emit_loads_output, out_load, out_valid_reg, "emit step did not load the output register")
    `MPSC_ASSERT_NXT(a_hold_left_no_beat, state_reg == S_MIX && hold_only, state_reg == S_IDLE && phase_reg, "held left sample did not arm the pair phase")

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import mpsc_pkg::*;

    localparam logic [1:0] REG_SPARE  = 2'd3;
    localparam logic [1:0] CODE_SPARE = 2'd3;
    localparam int MULAW_BIAS = 132;
    localparam int MULAW_CLIP = 32635;
    localparam int DRAIN_CYCLES = 24;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [GAIN_BITS-1:0]   gain;
        logic                   last;
    } in_beat_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last;
        logic [SAMPLE_BITS-1:0] peak;
        logic                   malformed;
    } out_beat_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_BITS-1:0]  paddr = '0;
    logic [PDATA_BITS-1:0]  pwdata = '0;
    logic [PDATA_BITS-1:0]  prdata;
    logic                   pready;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [SAMPLE_BITS-1:0] sample_in = '0;
    logic [GAIN_BITS-1:0]   gain = '0;
    logic                   last_in = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [SAMPLE_BITS-1:0] sample_out;
    logic                   last_out;
    logic [SAMPLE_BITS-1:0] peak_level;
    logic                   malformed;

    mulaw_pcm_sample_converter_unit dut (.*);

    always #4 clk = ~clk;

    // predictor state and register copies
    logic [1:0]  in_fmt = FMT_S16;
    logic [1:0]  out_fmt = FMT_S16;
    logic [1:0]  mix_mode = MODE_PASS;
    logic [15:0] peak_hold = '0;
    longint      held_left_val = 0;
    bit          right_next = 1'b0;

    in_beat_t  sample_q[$];
    out_beat_t converted_q[$];
    int        issued = 0;
    int        accepted = 0;
    int        mismatches = 0;
    bit        in_taken = 1'b0;
    int        send_gap = 0;
    int        stall_left = 0;
    bit        send_idle_on = 1'b1;
    bit        stall_on = 1'b1;

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic logic [15:0] encode_level(input longint v);
        longint     c;
        longint     pcm;
        longint     t;
        logic [7:0] mask;
        int         seg;
        if (out_fmt == FMT_MULAW)
        begin
            c = clamp_to(v, -32768, 32767);
            if (c < 0)
            begin
                pcm  = MULAW_BIAS - c;
                mask = 8'h7F;
            end
            else
            begin
                pcm  = MULAW_BIAS + c;
                mask = 8'hFF;
            end
            if (pcm > MULAW_BIAS + MULAW_CLIP)
            begin
                pcm = MULAW_BIAS + MULAW_CLIP;
            end
            seg = 0;
            while (seg < 7 && pcm > (longint'(256) << seg) - 1)
            begin
                seg++;
            end
            return 16'({1'b0, seg[2:0], 4'(pcm >> (seg + 3))} ^ mask);
        end
        if (out_fmt == FMT_U8)
        begin
            c = clamp_to(v, -32768, 32768);
            t = c * 127 + 128 * 32768 + 16384;
            return 16'((t >>> 15) & 255);
        end
        return 16'(clamp_to(v, -32768, 32767));
    endfunction

    task automatic push_result(input longint v, input bit last, input bit bad);
        out_beat_t r;
        r.sample    = encode_level(v);
        r.last      = last;
        r.peak      = last ? peak_hold : 16'd0;
        r.malformed = bad;
        if (last)
        begin
            peak_hold = '0;
        end
        converted_q.push_back(r);
    endtask

    task automatic convert_sample(input in_beat_t b);
        longint     v;
        longint     mag;
        longint     g;
        logic [7:0] u;
        u = ~b.sample[7:0];
        case (in_fmt)
            FMT_MULAW:
            begin
                mag = (((longint'(u[3:0]) << 3) + MULAW_BIAS) << u[6:4]) - MULAW_BIAS;
                v   = u[7] ? -mag : mag;
            end
            FMT_U8:
            begin
                v = clamp_to((longint'(b.sample[7:0]) - 128) * 258, -32768, 32767);
            end
            default:
            begin
                v = longint'($signed(b.sample));
            end
        endcase
        mag = (v < 0) ? -v : v;
        if (mag > peak_hold)
        begin
            peak_hold = 16'(mag);
        end
        g = (v * longint'(b.gain) + (longint'(1) << (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS;
        g = clamp_to(g, -524288, 524287);
        if (mix_mode == MODE_DOWNMIX)
        begin
            if (!right_next)
            begin
                if (b.last)
                begin
                    push_result(g >>> 1, 1'b1, 1'b1);
                end
                else
                begin
                    held_left_val = g;
                    right_next    = 1'b1;
                end
            end
            else
            begin
                right_next = 1'b0;
                push_result((held_left_val + g) >>> 1, b.last, 1'b0);
            end
        end
        else
        begin
            right_next = 1'b0;
            if (mix_mode == MODE_DUP)
            begin
                push_result(g, 1'b0, 1'b0);
            end
            push_result(g, b.last, 1'b0);
        end
    endtask

    function automatic int pick_gap(input bit on);
        int r;
        if (!on)
        begin
            return 0;
        end
        r = $urandom_range(0, 19);
        if (r < 12)
        begin
            return 0;
        end
        if (r < 18)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 19)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(11, 30);
    endfunction

    // input side: take beat at rising edge, drive next at falling edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            convert_sample({sample_in, gain, last_in});
            accepted++;
            in_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        in_beat_t nb;
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (sample_q.size() != 0)
            begin
                nb = sample_q.pop_front();
                sample_in <= nb.sample;
                gain      <= nb.gain;
                last_in   <= nb.last;
                in_valid  <= 1'b1;
                send_gap  = pick_gap(send_idle_on);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        in_taken = 1'b0;
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = pick_gap(stall_on);
        end
    end

    // output side: check each beat against the oldest prediction
    always @(posedge clk)
    begin
        out_beat_t got;
        out_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {sample_out, last_out, peak_level, malformed};
            if (converted_q.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got sample %h last %b peak %h malformed %b",
                         $time, got.sample, got.last, got.peak, got.malformed);
                mismatches++;
            end
            else
            begin
                want = converted_q.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected sample %h last %b peak %h malformed %b",
                             $time, want.sample, want.last, want.peak, want.malformed);
                    $display("%0t:          actual   sample %h last %b peak %h malformed %b",
                             $time, got.sample, got.last, got.peak, got.malformed);
                    mismatches++;
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_BITS'({idx, 2'b00});
        pwdata  <= PDATA_BITS'(val);
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_INPUT_FORMAT:  in_fmt = val;
            REG_OUTPUT_FORMAT: out_fmt = val;
            REG_CHANNEL_MODE:  mix_mode = val;
            default:           ;
        endcase
    endtask

    task automatic configure(input logic [1:0] ifmt, input logic [1:0] ofmt,
                             input logic [1:0] mode);
        write_reg(REG_INPUT_FORMAT, ifmt);
        write_reg(REG_OUTPUT_FORMAT, ofmt);
        write_reg(REG_CHANNEL_MODE, mode);
        @(posedge clk);
    endtask

    task automatic add_item(input logic [15:0] s, input logic [15:0] g, input bit last);
        sample_q.push_back({s, g, last});
        issued++;
    endtask

    task automatic drain();
        while (accepted != issued || converted_q.size() != 0)
        begin
            @(negedge clk);
        end
        // held left samples give no beat; let the sequencer settle
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [1:0] pick_code();
        if ($urandom_range(0, 9) == 0)
        begin
            return CODE_SPARE;
        end
        return 2'($urandom_range(0, 2));
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'h00FF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return 16'd4096;
            1:       return 16'd0;
            2:       return 16'hFFFF;
            3, 4:    return 16'($urandom_range(0, 8191));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int n);
        int          count;
        int          len;
        logic [15:0] pg;
        logic [15:0] g;
        send_idle_on = ($urandom_range(0, 3) != 0);
        stall_on     = ($urandom_range(0, 3) != 0);
        configure(pick_code(), pick_code(), pick_code());
        count = 0;
        while (count < n)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            pg  = pick_gain();
            for (int k = 0; k < len; k++)
            begin
                g = ($urandom_range(0, 7) == 0) ? pick_gain() : pg;
                add_item(pick_sample(), g, k == len - 1);
            end
            count += len;
        end
        // leave a packet open across the next register change
        if ($urandom_range(0, 2) == 0)
        begin
            add_item(pick_sample(), pick_gain(), 1'b0);
        end
        drain();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        configure(FMT_S16, FMT_S16, MODE_PASS);
        add_item(16'h7FFF, 16'd4096, 1'b0);
        add_item(16'h8000, 16'd4096, 1'b1);
        add_item(16'h0000, 16'd0, 1'b0);
        add_item(16'hFFFF, 16'hFFFF, 1'b1);
        add_item(16'h8000, 16'hFFFF, 1'b1);
        add_item(16'h7FFF, 16'hFFFF, 1'b1);
        drain();

        configure(FMT_MULAW, FMT_MULAW, MODE_DUP);
        add_item(16'hFF00, 16'd4096, 1'b0);
        add_item(16'h00FF, 16'd4096, 1'b0);
        add_item(16'h007F, 16'd4096, 1'b0);
        add_item(16'h0080, 16'd4096, 1'b1);
        drain();

        configure(FMT_U8, FMT_U8, MODE_DOWNMIX);
        add_item(16'h0000, 16'd4096, 1'b0);
        add_item(16'hFFFF, 16'd4096, 1'b0);
        add_item(16'h0080, 16'd4096, 1'b1);
        add_item(16'h0001, 16'hFFFF, 1'b0);
        add_item(16'h00FE, 16'hFFFF, 1'b1);
        drain();

        configure(CODE_SPARE, CODE_SPARE, CODE_SPARE);
        write_reg(REG_SPARE, MODE_DOWNMIX);
        @(posedge clk);
        add_item(16'hABCD, 16'h2000, 1'b0);
        add_item(16'h1234, 16'h0800, 1'b1);
        drain();

        configure(FMT_S16, FMT_U8, MODE_PASS);
        add_item(16'h7FFF, 16'hFFFF, 1'b0);
        add_item(16'h8000, 16'hFFFF, 1'b1);
        add_item(16'h0000, 16'd4096, 1'b1);
        drain();

        repeat (10) random_phase(200);

        if (mismatches == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
